/* src/keyboard_report_key_tracker_defines.svh */
// Assertion macros for the key tracker RTL.
// No dependencies; included by the files that carry assertions.
`ifndef KEYBOARD_REPORT_KEY_TRACKER_DEFINES_SVH
`define KEYBOARD_REPORT_KEY_TRACKER_DEFINES_SVH

// antecedent true -> consequent true in the same cycle
`define KRKT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("krkt check failed");

// antecedent true -> consequent true in the next cycle
`define KRKT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("krkt check failed");

`endif

/* src/krkt_pkg.sv */
// Shared types and codes for the keyboard report key tracker.
// No dependencies.
package krkt_pkg;

   localparam logic [1:0] KIND_KEY      = 2'd0;
   localparam logic [1:0] KIND_MODIFIER = 2'd1;
   localparam logic [1:0] KIND_CONSUMER = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic        pressed;
      logic [7:0]  code;
      logic [15:0] usage;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic        send_keys;
      logic        send_consumer;
      logic [7:0]  modifiers;
      logic [2:0]  held_count;
      logic [7:0]  slot0;
      logic [7:0]  slot1;
      logic [7:0]  slot2;
      logic [7:0]  slot3;
      logic [7:0]  slot4;
      logic [7:0]  slot5;
      logic [15:0] consumer_out;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE,
      ST_RESPOND
   } state_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_COMPARE,
      OP_APPEND,
      OP_REMOVE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic [7:0]  code;
   } cell_ctrl_type;

endpackage

/* src/krkt_cell.sv */
// One key slot of the held-key chain: holds a code and an occupied flag.
// Depends on krkt_pkg.
module krkt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  krkt_pkg::cell_ctrl_type ctrl,
   input  logic                   prev_occ,
   input  logic                   take_in,
   input  logic [7:0]             next_key,
   input  logic                   next_occ,
   output logic [7:0]             key,
   output logic                   occ,
   output logic                   take_out
);
   import krkt_pkg::*;

   logic [7:0] key_ff, key_in;
   logic       occ_ff, occ_in;
   logic       hit_ff, hit_in;

   // prefix of matches: this cell and all to its right shift left on removal
   assign take_out = take_in | hit_ff;

   always_comb begin
      key_in = key_ff;
      occ_in = occ_ff;
      hit_in = hit_ff;
      case (ctrl.op)
         OP_COMPARE: begin
            hit_in = occ_ff && (key_ff == ctrl.code);
         end
         OP_APPEND: begin
            if (!occ_ff && prev_occ) begin
               key_in = ctrl.code;
               occ_in = 1'b1;
            end
         end
         OP_REMOVE: begin
            if (take_out) begin
               key_in = next_key;
               occ_in = next_occ;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         occ_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         key_ff <= key_in;
         occ_ff <= occ_in;
         hit_ff <= hit_in;
      end
   end

   assign key = key_ff;
   assign occ = occ_ff;
endmodule

/* src/keyboard_report_key_tracker.sv */
// Top level: control sequencer plus a chain of SLOTS key cells.
// Depends on krkt_pkg, krkt_cell and keyboard_report_key_tracker_defines.svh.
//
//   channel   ports                    direction  handshake
//   request   start, busy, req_data    in         start && !busy
//   response  rsp_valid, rsp_data      out        rsp_valid, one cycle
//
// One transaction runs from acceptance through the compare, update and respond states
// to idle, where the next can be accepted: compare all cells, update the chain, then
// present the response in the respond state; busy stays high from acceptance until idle.
// Synchronous reset empties every slot and clears modifiers and usage.
// The receiver cannot stall; each response shows for exactly one cycle.
`include "keyboard_report_key_tracker_defines.svh"
module keyboard_report_key_tracker #(
   parameter int SLOTS = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  krkt_pkg::req_type req_data,
   output logic              rsp_valid,
   output krkt_pkg::rsp_type rsp_data
);
   import krkt_pkg::*;

   localparam int CNT_W = $clog2(SLOTS + 1);

   state_type      state_ff, state_in;
   req_type        req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]     mod_ff, mod_in;
   logic [15:0]    usage_ff, usage_in;
   logic           ok_ff, skeys_ff, scons_ff;
   logic           ok, skeys, scons;
   cell_ctrl_type  ctrl;

   logic [7:0]     cell_key [SLOTS];
   logic [SLOTS-1:0] cell_occ;
   logic [SLOTS:0] take;

   logic found, full, accept;

   assign accept = start && !busy;
   assign found  = take[SLOTS];
   assign full   = (count_ff == CNT_W'(SLOTS));
   assign take[0] = 1'b0;

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         logic       prev_occ, next_occ;
         logic [7:0] next_key;
         if (gi == 0) begin : g_first
            assign prev_occ = 1'b1;
         end else begin : g_mid
            assign prev_occ = cell_occ[gi-1];
         end
         if (gi == SLOTS - 1) begin : g_last
            assign next_key = '0;
            assign next_occ = 1'b0;
         end else begin : g_inner
            assign next_key = cell_key[gi+1];
            assign next_occ = cell_occ[gi+1];
         end
         krkt_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .prev_occ (prev_occ),
            .take_in  (take[gi]),
            .next_key (next_key),
            .next_occ (next_occ),
            .key      (cell_key[gi]),
            .occ      (cell_occ[gi]),
            .take_out (take[gi+1])
         );
      end
   endgenerate

   // event decision, evaluated in the update cycle
   always_comb begin
      ok    = 1'b0;
      skeys = 1'b0;
      scons = 1'b0;
      case (req_ff.kind)
         KIND_KEY: begin
            ok    = req_ff.pressed ? (!found && !full) : found;
            skeys = ok;
         end
         KIND_MODIFIER: begin
            ok = 1'b1;
         end
         KIND_CONSUMER: begin
            ok    = req_ff.pressed ? (usage_ff == '0) : (usage_ff != '0);
            scons = ok;
         end
         default: ;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (start) state_in = ST_COMPARE;
         ST_COMPARE: state_in = ST_UPDATE;
         ST_UPDATE:  state_in = ST_RESPOND;
         ST_RESPOND: state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      busy      = 1'b1;
      rsp_valid = 1'b0;
      ctrl.op   = OP_HOLD;
      ctrl.code = req_ff.code;
      unique case (state_ff)
         ST_IDLE:    busy = 1'b0;
         ST_COMPARE: if (req_ff.kind == KIND_KEY) ctrl.op = OP_COMPARE;
         ST_UPDATE: begin
            if (req_ff.kind == KIND_KEY && ok) begin
               ctrl.op = req_ff.pressed ? OP_APPEND : OP_REMOVE;
            end
         end
         ST_RESPOND: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      mod_in   = mod_ff;
      usage_in = usage_ff;
      if (state_ff == ST_UPDATE) begin
         case (req_ff.kind)
            KIND_KEY: begin
               if (ok) begin
                  count_in = req_ff.pressed ? count_ff + CNT_W'(1) : count_ff - CNT_W'(1);
               end
            end
            KIND_MODIFIER: begin
               if (req_ff.pressed) begin
                  mod_in = mod_ff | (8'd1 << req_ff.code[2:0]);
               end else begin
                  mod_in = mod_ff & ~(8'd1 << req_ff.code[2:0]);
               end
            end
            KIND_CONSUMER: begin
               usage_in = (req_ff.pressed && usage_ff == '0) ? req_ff.usage : 16'd0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         mod_ff   <= '0;
         usage_ff <= '0;
         ok_ff    <= 1'b0;
         skeys_ff <= 1'b0;
         scons_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         mod_ff   <= mod_in;
         usage_ff <= usage_in;
         if (state_ff == ST_UPDATE) begin
            ok_ff    <= ok;
            skeys_ff <= skeys;
            scons_ff <= scons;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
   end

   logic [7:0] slot_val [6];
   generate
      for (gi = 0; gi < 6; gi++) begin : g_slot
         if (gi < SLOTS) begin : g_on
            assign slot_val[gi] = cell_key[gi];
         end else begin : g_off
            assign slot_val[gi] = '0;
         end
      end
   endgenerate

   always_comb begin
      rsp_data.accepted      = ok_ff;
      rsp_data.send_keys     = skeys_ff;
      rsp_data.send_consumer = scons_ff;
      rsp_data.modifiers     = mod_ff;
      rsp_data.held_count    = (32'(count_ff) > 32'd7) ? 3'd7 : 3'(count_ff);
      rsp_data.slot0         = slot_val[0];
      rsp_data.slot1         = slot_val[1];
      rsp_data.slot2         = slot_val[2];
      rsp_data.slot3         = slot_val[3];
      rsp_data.slot4         = slot_val[4];
      rsp_data.slot5         = slot_val[5];
      rsp_data.consumer_out  = usage_ff;
   end

   `KRKT_ASSERT_NOW(a_occ_matches_count, clock, reset, 1'b1, 32'($countones(cell_occ)) == 32'(count_ff))
   `KRKT_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, 32'(count_ff) <= 32'(SLOTS))
   `KRKT_ASSERT_NEXT(a_accept_starts_compare, clock, reset, accept, state_ff == ST_COMPARE)
   `KRKT_ASSERT_NOW(a_send_needs_accept, clock, reset, rsp_valid && (skeys_ff || scons_ff), ok_ff)
endmodule

/* tb/sv/krkt_report_checker.sv */
`timescale 1ns / 1ps
// Checker for the keyboard report key tracker: watches both channels, keeps its own
// copy of the key list, modifier byte and consumer usage, and compares every report.
// Depends on krkt_pkg for the request and response payload types.
module krkt_report_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  krkt_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  krkt_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                pending
);
   import krkt_pkg::*;

   localparam int SLOT_COUNT = 6;
   localparam int PRINT_LIMIT = 40;

   logic [7:0]  held_codes [SLOT_COUNT];
   int          held_total;
   logic [7:0]  modifier_byte;
   logic [15:0] consumer_usage;
   rsp_type     report_q[$];

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_LIMIT) begin
         $display("[%0t] mismatch: %s", $time, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   function automatic int find_code(input logic [7:0] code);
      int pos;
      pos = -1;
      for (int i = 0; i < held_total; i++) begin
         if (held_codes[i] == code) pos = i;
      end
      return pos;
   endfunction

   // Applies one event to the tracked report and returns the report it should produce.
   task automatic apply_event(input req_type ev, output rsp_type rep);
      int    pos;
      logic  ok;
      logic  key_change;
      logic  usage_change;
      ok = 1'b0;
      key_change = 1'b0;
      usage_change = 1'b0;
      case (ev.kind)
         KIND_KEY: begin
            pos = find_code(ev.code);
            if (ev.pressed) begin
               if (held_total < SLOT_COUNT && pos < 0) begin
                  held_codes[held_total] = ev.code;
                  held_total++;
                  ok = 1'b1;
               end
            end else if (pos >= 0) begin
               // close the gap left by the released code
               for (int i = pos; i + 1 < held_total; i++) begin
                  held_codes[i] = held_codes[i + 1];
               end
               held_total--;
               held_codes[held_total] = 8'h00;
               ok = 1'b1;
            end
            key_change = ok;
         end
         KIND_MODIFIER: begin
            if (ev.pressed) begin
               modifier_byte = modifier_byte | (8'h01 << ev.code[2:0]);
            end else begin
               modifier_byte = modifier_byte & ~(8'h01 << ev.code[2:0]);
            end
            ok = 1'b1;
         end
         KIND_CONSUMER: begin
            if (ev.pressed) begin
               // a second press while one is held drops the held usage
               ok = (consumer_usage == 16'h0000);
               consumer_usage = ok ? ev.usage : 16'h0000;
            end else begin
               ok = (consumer_usage != 16'h0000);
               consumer_usage = 16'h0000;
            end
            usage_change = ok;
         end
         default: begin
         end
      endcase
      rep.accepted      = ok;
      rep.send_keys     = key_change;
      rep.send_consumer = usage_change;
      rep.modifiers     = modifier_byte;
      rep.held_count    = 3'(held_total);
      rep.slot0         = held_codes[0];
      rep.slot1         = held_codes[1];
      rep.slot2         = held_codes[2];
      rep.slot3         = held_codes[3];
      rep.slot4         = held_codes[4];
      rep.slot5         = held_codes[5];
      rep.consumer_out  = consumer_usage;
   endtask

   task automatic compare_report(input rsp_type got, input rsp_type want);
      check_field("accepted", 16'(got.accepted), 16'(want.accepted));
      check_field("send_keys", 16'(got.send_keys), 16'(want.send_keys));
      check_field("send_consumer", 16'(got.send_consumer), 16'(want.send_consumer));
      check_field("modifiers", 16'(got.modifiers), 16'(want.modifiers));
      check_field("held_count", 16'(got.held_count), 16'(want.held_count));
      check_field("slot0", 16'(got.slot0), 16'(want.slot0));
      check_field("slot1", 16'(got.slot1), 16'(want.slot1));
      check_field("slot2", 16'(got.slot2), 16'(want.slot2));
      check_field("slot3", 16'(got.slot3), 16'(want.slot3));
      check_field("slot4", 16'(got.slot4), 16'(want.slot4));
      check_field("slot5", 16'(got.slot5), 16'(want.slot5));
      check_field("consumer_out", got.consumer_out, want.consumer_out);
   endtask

   initial begin
      mismatches = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) held_codes[i] = 8'h00;
         held_total = 0;
         modifier_byte = 8'h00;
         consumer_usage = 16'h0000;
         report_q.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            if (report_q.size() == 0) begin
               report_mismatch("report with no transaction outstanding");
            end else begin
               compare_report(rsp_data, report_q.pop_front());
            end
         end
         if (start === 1'b1 && busy === 1'b0) begin
            apply_event(req_data, want);
            report_q.push_back(want);
         end
      end
      pending <= report_q.size();
   end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// Testbench top for the keyboard report key tracker: clock, reset, event stimulus
// and verdict. Depends on krkt_pkg, keyboard_report_key_tracker and krkt_report_checker.
module tb;
   import krkt_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;
   localparam int PHASE_ITEMS = 225;
   localparam int DRAIN_CYCLES = 8;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      mismatches;
   int      pending;
   int      idle_cycles;
   int      reports_seen;
   int      kind_counts [4];

   keyboard_report_key_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   krkt_report_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // watchdog: no transaction on either channel for too long ends the run
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
         if (rsp_valid) reports_seen <= reports_seen + 1;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic req_type make_event(input logic [1:0] kind, input logic pressed,
                                          input logic [7:0] code, input logic [15:0] usage);
      req_type ev;
      ev.kind = kind;
      ev.pressed = pressed;
      ev.code = code;
      ev.usage = usage;
      return ev;
   endfunction

   // Small code pool most of the time so presses and releases find each other.
   function automatic req_type random_event();
      int          sel;
      logic [1:0]  kind;
      logic [7:0]  code;
      logic [15:0] usage;
      sel = $urandom_range(99);
      if (sel < 50) kind = KIND_KEY;
      else if (sel < 70) kind = KIND_MODIFIER;
      else if (sel < 94) kind = KIND_CONSUMER;
      else kind = KIND_UNUSED;
      code = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(9));
      usage = ($urandom_range(9) == 0) ? 16'h0000 : 16'($urandom_range(65535));
      return make_event(kind, 1'($urandom_range(1)), code, usage);
   endfunction

   function automatic int pick_gap(input int pct);
      int gap;
      gap = 0;
      while (gap < 30 && $urandom_range(99) < pct) gap++;
      return gap;
   endfunction

   // start stays high across back-to-back events; only one assignment per edge
   task automatic send_event(input req_type ev, input int gap);
      if (gap > 0) begin
         start <= 1'b0;
         // idle cycles count only once the block is ready again
         @(posedge clock);
         while (busy) @(posedge clock);
         repeat (gap - 1) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= ev;
      do @(posedge clock); while (busy);
      kind_counts[ev.kind]++;
   endtask

   task automatic send_random_phase(input int idle_pct);
      int      sent;
      req_type ev;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         ev = random_event();
         send_event(ev, pick_gap(idle_pct));
         if (ev.kind != KIND_UNUSED) sent++;
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      reports_seen = 0;
      for (int i = 0; i < 4; i++) kind_counts[i] = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // key list: duplicate, code zero, extremes, full list, compaction, misses
      send_event(make_event(KIND_KEY, 1'b1, 8'h04, 16'h0000), 0);
      send_event(make_event(KIND_KEY, 1'b1, 8'h04, 16'hFFFF), 0);
      send_event(make_event(KIND_KEY, 1'b1, 8'h00, 16'h0000), 0);
      send_event(make_event(KIND_KEY, 1'b1, 8'h05, 16'h0000), 1);
      send_event(make_event(KIND_KEY, 1'b1, 8'h06, 16'h0000), 0);
      send_event(make_event(KIND_KEY, 1'b1, 8'hFF, 16'h0000), 2);
      send_event(make_event(KIND_KEY, 1'b1, 8'h07, 16'h0000), 0);
      send_event(make_event(KIND_KEY, 1'b1, 8'h08, 16'h0000), 0);
      send_event(make_event(KIND_KEY, 1'b0, 8'h06, 16'h0000), 0);
      send_event(make_event(KIND_KEY, 1'b0, 8'h09, 16'h0000), 0);
      send_event(make_event(KIND_KEY, 1'b0, 8'h07, 16'h0000), 3);
      send_event(make_event(KIND_KEY, 1'b0, 8'h00, 16'h0000), 0);
      // modifiers: lowest and highest bit, upper code bits ignored
      send_event(make_event(KIND_MODIFIER, 1'b1, 8'h00, 16'h0000), 0);
      send_event(make_event(KIND_MODIFIER, 1'b1, 8'hFF, 16'h0000), 0);
      send_event(make_event(KIND_MODIFIER, 1'b1, 8'h0B, 16'h0000), 0);
      send_event(make_event(KIND_MODIFIER, 1'b0, 8'h07, 16'h0000), 0);
      // consumer: store, second press drops it, empty release, zero usage
      send_event(make_event(KIND_CONSUMER, 1'b1, 8'h00, 16'hFFFF), 0);
      send_event(make_event(KIND_CONSUMER, 1'b1, 8'hFF, 16'h1234), 0);
      send_event(make_event(KIND_CONSUMER, 1'b0, 8'h00, 16'h0000), 0);
      send_event(make_event(KIND_CONSUMER, 1'b1, 8'h00, 16'h0000), 0);
      send_event(make_event(KIND_CONSUMER, 1'b0, 8'h00, 16'h0000), 0);
      send_event(make_event(KIND_CONSUMER, 1'b1, 8'h00, 16'h00E9), 0);
      send_event(make_event(KIND_CONSUMER, 1'b0, 8'h00, 16'h0000), 0);
      // unused event class changes nothing
      send_event(make_event(KIND_UNUSED, 1'b1, 8'h04, 16'hFFFF), 0);
      send_event(make_event(KIND_UNUSED, 1'b0, 8'h05, 16'h0000), 0);

      send_random_phase(0);
      send_random_phase(62);
      send_random_phase(0);
      send_random_phase(32);
      start <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("events: %0d key, %0d modifier, %0d consumer, %0d unused class",
               kind_counts[KIND_KEY], kind_counts[KIND_MODIFIER],
               kind_counts[KIND_CONSUMER], kind_counts[KIND_UNUSED]);
      $display("%0d reports compared across idle and back-to-back phases, %0d mismatches",
               reports_seen, mismatches);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+src
src/krkt_pkg.sv
src/krkt_cell.sv
src/keyboard_report_key_tracker.sv
tb/sv/krkt_report_checker.sv
tb/sv/tb.sv
